@@ hdl/cce_pkg.sv @@
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants, command/status types and calendar helpers for the
// calendar clock epoch converter.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN   = 32'd60;
  localparam logic [16:0] DIV_MS         = 17'd1000;
  localparam logic [16:0] DIV_DAY        = 17'd86400;
  localparam logic [16:0] DIV_HOUR       = 17'd3600;
  localparam logic [16:0] DIV_MIN        = 17'd60;

  // floor(2^32 / divisor); the quotient estimate is low by at most one
  localparam logic [31:0] RCP_MS         = 32'd4294967;
  localparam logic [31:0] RCP_DAY        = 32'd49710;
  localparam logic [31:0] RCP_HOUR       = 32'd1193046;
  localparam logic [31:0] RCP_MIN        = 32'd71582788;

  // datapath operations
  typedef logic [3:0] cce_op_t;
  localparam cce_op_t OP_NOP       = 4'd0;
  localparam cce_op_t OP_LOAD      = 4'd1;
  localparam cce_op_t OP_SYEAR     = 4'd2;
  localparam cce_op_t OP_SMON      = 4'd3;
  localparam cce_op_t OP_SDAY      = 4'd4;
  localparam cce_op_t OP_MUL       = 4'd5;
  localparam cce_op_t OP_COMMIT    = 4'd6;
  localparam cce_op_t OP_DIV_START = 4'd7;
  localparam cce_op_t OP_DIV_STEP  = 4'd8;
  localparam cce_op_t OP_TS        = 4'd9;
  localparam cce_op_t OP_DAYS      = 4'd10;
  localparam cce_op_t OP_HOUR      = 4'd11;
  localparam cce_op_t OP_RYEAR     = 4'd12;
  localparam cce_op_t OP_RMON      = 4'd13;
  localparam cce_op_t OP_OUT       = 4'd14;

  // divider operand select
  typedef logic [1:0] cce_dsel_t;
  localparam cce_dsel_t DSEL_MS   = 2'd0;
  localparam cce_dsel_t DSEL_DAY  = 2'd1;
  localparam cce_dsel_t DSEL_HOUR = 2'd2;
  localparam cce_dsel_t DSEL_MIN  = 2'd3;

  typedef struct packed {
    cce_op_t   op;
    cce_dsel_t dsel;
  } cce_cmd_t;

  typedef struct packed {
    logic clk_valid;  // clock has been set
    logic year_lt;    // set: year counter below target year
    logic mon_go;     // set: another whole month to add
    logic year_ge;    // read: remaining days cover the current year
    logic mon_fit;    // read: remaining days fall in the current month
    logic mon_last;   // read: month counter at december
    logic div_last;   // divider on its final step
    logic out_free;   // output register can take a beat
  } cce_sts_t;

  // y mod 25 by restoring subtraction, eight steps on 12 bits
  function automatic logic [4:0] mod25(input logic [11:0] y);
    logic [11:0] r;
    r = y;
    for (int k = 7; k >= 0; k--) begin
      if (r >= (12'd25 << k)) begin
        r = r - (12'd25 << k);
      end
    end
    return r[4:0];
  endfunction

  // div by 4, and not by 100 unless by 400 (400 = 16 * 25)
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && ((mod25(y) != 5'd0) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [8:0] year_len(input logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/cce_ctrl.sv @@
// ----------------------------------------------------------------------------
// cce_ctrl
// Sequencer: walks the set and read procedures and issues one datapath
// command per cycle.
// ----------------------------------------------------------------------------
module cce_ctrl import cce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_stall,
  input  cce_sts_t sts,
  output cce_cmd_t cmd
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_SYEAR     = 5'd1;
  localparam logic [4:0] ST_SMON      = 5'd2;
  localparam logic [4:0] ST_SDAY      = 5'd3;
  localparam logic [4:0] ST_SMUL      = 5'd4;
  localparam logic [4:0] ST_SCOMMIT   = 5'd5;
  localparam logic [4:0] ST_MS_START  = 5'd6;
  localparam logic [4:0] ST_MS_DIV    = 5'd7;
  localparam logic [4:0] ST_TS        = 5'd8;
  localparam logic [4:0] ST_DAY_START = 5'd9;
  localparam logic [4:0] ST_DAY_DIV   = 5'd10;
  localparam logic [4:0] ST_DAYS      = 5'd11;
  localparam logic [4:0] ST_HR_START  = 5'd12;
  localparam logic [4:0] ST_HR_DIV    = 5'd13;
  localparam logic [4:0] ST_HR_CAP    = 5'd14;
  localparam logic [4:0] ST_MN_START  = 5'd15;
  localparam logic [4:0] ST_MN_DIV    = 5'd16;
  localparam logic [4:0] ST_RYEAR     = 5'd17;
  localparam logic [4:0] ST_RMON      = 5'd18;
  localparam logic [4:0] ST_EMIT      = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd.op    = OP_NOP;
    cmd.dsel  = DSEL_MS;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (!in_func) begin
            state_nxt = ST_SYEAR;
          end else if (!sts.clk_valid) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_MS_START;
          end
        end
      end
      ST_SYEAR: begin
        if (sts.year_lt) begin
          cmd.op = OP_SYEAR;
        end else begin
          state_nxt = ST_SMON;
        end
      end
      ST_SMON: begin
        if (sts.mon_go) begin
          cmd.op = OP_SMON;
        end else begin
          state_nxt = ST_SDAY;
        end
      end
      ST_SDAY: begin
        cmd.op    = OP_SDAY;
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_SCOMMIT;
      end
      ST_SCOMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = ST_IDLE;
      end
      ST_MS_START: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_MS;
        state_nxt = ST_MS_DIV;
      end
      ST_MS_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = ST_TS;
        end
      end
      ST_TS: begin
        cmd.op    = OP_TS;
        state_nxt = ST_DAY_START;
      end
      ST_DAY_START: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_DAY;
        state_nxt = ST_DAY_DIV;
      end
      ST_DAY_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = ST_DAYS;
        end
      end
      ST_DAYS: begin
        cmd.op    = OP_DAYS;
        state_nxt = ST_HR_START;
      end
      ST_HR_START: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_HOUR;
        state_nxt = ST_HR_DIV;
      end
      ST_HR_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = ST_HR_CAP;
        end
      end
      ST_HR_CAP: begin
        cmd.op    = OP_HOUR;
        state_nxt = ST_MN_START;
      end
      ST_MN_START: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_MIN;
        state_nxt = ST_MN_DIV;
      end
      ST_MN_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = ST_RYEAR;
        end
      end
      ST_RYEAR: begin
        if (sts.year_ge) begin
          cmd.op = OP_RYEAR;
        end else begin
          state_nxt = ST_RMON;
        end
      end
      ST_RMON: begin
        if (sts.mon_fit || sts.mon_last) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.op = OP_RMON;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/cce_dpath.sv @@
// ----------------------------------------------------------------------------
// cce_dpath
// Datapath: set-field latches, day accumulator with year and month counters,
// reciprocal constant divider, set multipliers, clock base and output register.
// ----------------------------------------------------------------------------
module cce_dpath import cce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cce_cmd_t    cmd,
  input  logic [31:0] in_now_ms,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_is_set,
  output logic [31:0] out_epoch_seconds,
  output logic [11:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second,
  output cce_sts_t    sts
);

  // latched item
  logic [31:0] now_r,     now_nxt;
  logic [11:0] syear_r,   syear_nxt;
  logic [3:0]  smon_r,    smon_nxt;
  logic [4:0]  sday_r,    sday_nxt;
  logic [4:0]  shour_r,   shour_nxt;
  logic [5:0]  smin_r,    smin_nxt;
  logic [5:0]  ssec_r,    ssec_nxt;
  // clock base
  logic [31:0] base_sec_r, base_sec_nxt;
  logic [31:0] base_ms_r,  base_ms_nxt;
  logic        valid_r,    valid_nxt;
  // working registers
  logic [11:0] yr_r,    yr_nxt;
  logic [3:0]  mon_r,   mon_nxt;
  logic [31:0] days_r,  days_nxt;
  logic [31:0] prod_r,  prod_nxt;
  logic [31:0] hms_r,   hms_nxt;
  logic [31:0] ts_r,    ts_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  // divider
  logic [31:0] num_r,   num_nxt;
  logic [31:0] rcp_r,   rcp_nxt;
  logic [16:0] dvr_r,   dvr_nxt;
  logic [17:0] rem_r,   rem_nxt;
  logic [31:0] quo_r,   quo_nxt;
  logic [1:0]  dcnt_r,  dcnt_nxt;
  // output register
  logic        ov_r,    ov_nxt;
  logic        oset_r,  oset_nxt;
  logic [31:0] oepo_r,  oepo_nxt;
  logic [11:0] oyr_r,   oyr_nxt;
  logic [3:0]  omon_r,  omon_nxt;
  logic [4:0]  oday_r,  oday_nxt;
  logic [4:0]  ohr_r,   ohr_nxt;
  logic [5:0]  omin_r,  omin_nxt;
  logic [5:0]  osec_r,  osec_nxt;

  logic [8:0]  ylen;
  logic [4:0]  md_rd;
  logic [4:0]  md_set;
  logic [63:0] rprod;
  logic [31:0] qd_diff;
  logic        out_free;

  assign ylen   = year_len(yr_r);
  assign md_rd  = month_days(mon_r, is_leap(yr_r));
  assign md_set = month_days(mon_r, is_leap(syear_r));

  // quotient estimate from the reciprocal, then remainder and one fix-up
  assign rprod   = {32'd0, num_r} * {32'd0, rcp_r};
  assign qd_diff = num_r - quo_r * {15'd0, dvr_r};

  assign out_free = !ov_r || !out_stall;

  assign sts.clk_valid = valid_r;
  assign sts.year_lt   = (yr_r < syear_r);
  assign sts.mon_go    = (mon_r < smon_r) && (mon_r <= 4'd12);
  assign sts.year_ge   = (days_r >= {23'd0, ylen});
  assign sts.mon_fit   = (days_r < {27'd0, md_rd});
  assign sts.mon_last  = (mon_r == 4'd12);
  assign sts.div_last  = (dcnt_r == 2'd2);
  assign sts.out_free  = out_free;

  always_comb begin
    now_nxt      = now_r;
    syear_nxt    = syear_r;
    smon_nxt     = smon_r;
    sday_nxt     = sday_r;
    shour_nxt    = shour_r;
    smin_nxt     = smin_r;
    ssec_nxt     = ssec_r;
    base_sec_nxt = base_sec_r;
    base_ms_nxt  = base_ms_r;
    valid_nxt    = valid_r;
    yr_nxt       = yr_r;
    mon_nxt      = mon_r;
    days_nxt     = days_r;
    prod_nxt     = prod_r;
    hms_nxt      = hms_r;
    ts_nxt       = ts_r;
    hour_nxt     = hour_r;
    num_nxt      = num_r;
    rcp_nxt      = rcp_r;
    dvr_nxt      = dvr_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    dcnt_nxt     = dcnt_r;
    ov_nxt       = ov_r && out_stall;
    oset_nxt     = oset_r;
    oepo_nxt     = oepo_r;
    oyr_nxt      = oyr_r;
    omon_nxt     = omon_r;
    oday_nxt     = oday_r;
    ohr_nxt      = ohr_r;
    omin_nxt     = omin_r;
    osec_nxt     = osec_r;

    case (cmd.op)
      OP_LOAD: begin
        now_nxt   = in_now_ms;
        syear_nxt = in_set_year;
        smon_nxt  = in_set_month;
        sday_nxt  = in_set_day;
        shour_nxt = in_set_hour;
        smin_nxt  = in_set_minute;
        ssec_nxt  = in_set_second;
        yr_nxt    = EPOCH_YEAR;
        mon_nxt   = 4'd1;
        days_nxt  = 32'd0;
      end
      OP_SYEAR: begin
        days_nxt = days_r + {23'd0, ylen};
        yr_nxt   = yr_r + 12'd1;
      end
      OP_SMON: begin
        days_nxt = days_r + {27'd0, md_set};
        mon_nxt  = mon_r + 4'd1;
      end
      OP_SDAY: begin
        // day zero wraps the offset below zero
        days_nxt = days_r + {27'd0, sday_r} - 32'd1;
      end
      OP_MUL: begin
        prod_nxt = days_r * SECS_PER_DAY;
        hms_nxt  = {27'd0, shour_r} * SECS_PER_HOUR + {26'd0, smin_r} * SECS_PER_MIN
                 + {26'd0, ssec_r};
      end
      OP_COMMIT: begin
        base_sec_nxt = prod_r + hms_r;
        base_ms_nxt  = now_r;
        valid_nxt    = 1'b1;
      end
      OP_DIV_START: begin
        dcnt_nxt = 2'd0;
        case (cmd.dsel)
          DSEL_MS: begin
            num_nxt = now_r - base_ms_r;
            rcp_nxt = RCP_MS;
            dvr_nxt = DIV_MS;
          end
          DSEL_DAY: begin
            num_nxt = ts_r;
            rcp_nxt = RCP_DAY;
            dvr_nxt = DIV_DAY;
          end
          DSEL_HOUR: begin
            num_nxt = {14'd0, rem_r};
            rcp_nxt = RCP_HOUR;
            dvr_nxt = DIV_HOUR;
          end
          default: begin
            num_nxt = {14'd0, rem_r};
            rcp_nxt = RCP_MIN;
            dvr_nxt = DIV_MIN;
          end
        endcase
      end
      OP_DIV_STEP: begin
        case (dcnt_r)
          2'd0: begin
            quo_nxt = rprod[63:32];
          end
          2'd1: begin
            // below twice the divisor, fits 18 bits
            rem_nxt = qd_diff[17:0];
          end
          default: begin
            if (rem_r >= {1'b0, dvr_r}) begin
              rem_nxt = rem_r - {1'b0, dvr_r};
              quo_nxt = quo_r + 32'd1;
            end
          end
        endcase
        dcnt_nxt = dcnt_r + 2'd1;
      end
      OP_TS: begin
        ts_nxt = base_sec_r + quo_r;
      end
      OP_DAYS: begin
        days_nxt = quo_r;
        yr_nxt   = EPOCH_YEAR;
        mon_nxt  = 4'd1;
      end
      OP_HOUR: begin
        hour_nxt = quo_r[4:0];
      end
      OP_RYEAR: begin
        days_nxt = days_r - {23'd0, ylen};
        yr_nxt   = yr_r + 12'd1;
      end
      OP_RMON: begin
        days_nxt = days_r - {27'd0, md_rd};
        mon_nxt  = mon_r + 4'd1;
      end
      OP_OUT: begin
        ov_nxt = 1'b1;
        if (valid_r) begin
          oset_nxt = 1'b1;
          oepo_nxt = ts_r;
          oyr_nxt  = yr_r;
          omon_nxt = mon_r;
          oday_nxt = days_r[4:0] + 5'd1;
          ohr_nxt  = hour_r;
          omin_nxt = quo_r[5:0];
          osec_nxt = rem_r[5:0];
        end else begin
          oset_nxt = 1'b0;
          oepo_nxt = 32'd0;
          oyr_nxt  = 12'd0;
          omon_nxt = 4'd0;
          oday_nxt = 5'd0;
          ohr_nxt  = 5'd0;
          omin_nxt = 6'd0;
          osec_nxt = 6'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      base_sec_r <= 32'd0;
      base_ms_r  <= 32'd0;
      ov_r       <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      base_sec_r <= base_sec_nxt;
      base_ms_r  <= base_ms_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    syear_r <= syear_nxt;
    smon_r  <= smon_nxt;
    sday_r  <= sday_nxt;
    shour_r <= shour_nxt;
    smin_r  <= smin_nxt;
    ssec_r  <= ssec_nxt;
    yr_r    <= yr_nxt;
    mon_r   <= mon_nxt;
    days_r  <= days_nxt;
    prod_r  <= prod_nxt;
    hms_r   <= hms_nxt;
    ts_r    <= ts_nxt;
    hour_r  <= hour_nxt;
    num_r   <= num_nxt;
    rcp_r   <= rcp_nxt;
    dvr_r   <= dvr_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dcnt_r  <= dcnt_nxt;
    oset_r  <= oset_nxt;
    oepo_r  <= oepo_nxt;
    oyr_r   <= oyr_nxt;
    omon_r  <= omon_nxt;
    oday_r  <= oday_nxt;
    ohr_r   <= ohr_nxt;
    omin_r  <= omin_nxt;
    osec_r  <= osec_nxt;
  end

  assign out_valid         = ov_r;
  assign out_is_set        = oset_r;
  assign out_epoch_seconds = oepo_r;
  assign out_cal_year      = oyr_r;
  assign out_cal_month     = omon_r;
  assign out_cal_day       = oday_r;
  assign out_cal_hour      = ohr_r;
  assign out_cal_minute    = omin_r;
  assign out_cal_second    = osec_r;

endmodule

@@ hdl/calendar_clock_epoch_converter_top.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_epoch_converter_top
// Software-style real-time clock: set converts a calendar date to Unix
// seconds and latches the millisecond count, read returns the current time.
//
//   channel  | direction | handshake         | beat
//   in_      | input     | in_valid/in_stall | func, now_ms, set date and time
//   out_     | output    | out_valid/out_stall | is_set, seconds, calendar
//
// One item at a time; in_stall is high from acceptance to the end of its work.
// Set walks the years from 1970 to set_year and the months before set_month, then commits.
// Read runs four reciprocal divisions and the year/month walk;
// a read of an unset clock goes straight to the output.
// The result waits in an output register; the next item is taken meanwhile.
// Synchronous active-low reset clears the clock base, valid flag and output valid, no sweep.
// ----------------------------------------------------------------------------
module calendar_clock_epoch_converter_top import cce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_now_ms,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_set,
  output logic [31:0] out_epoch_seconds,
  output logic [11:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second
);

  cce_cmd_t cmd;
  cce_sts_t sts;

  cce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cce_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_now_ms         (in_now_ms),
    .in_set_year       (in_set_year),
    .in_set_month      (in_set_month),
    .in_set_day        (in_set_day),
    .in_set_hour       (in_set_hour),
    .in_set_minute     (in_set_minute),
    .in_set_second     (in_set_second),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_is_set        (out_is_set),
    .out_epoch_seconds (out_epoch_seconds),
    .out_cal_year      (out_cal_year),
    .out_cal_month     (out_cal_month),
    .out_cal_day       (out_cal_day),
    .out_cal_hour      (out_cal_hour),
    .out_cal_minute    (out_cal_minute),
    .out_cal_second    (out_cal_second),
    .sts               (sts)
  );

endmodule

@@ hdl/cce_checker.sv @@
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks for the calendar clock epoch converter, bound to the top.
// ----------------------------------------------------------------------------
module cce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic [31:0] in_now_ms,
  input logic [11:0] in_set_year,
  input logic [3:0]  in_set_month,
  input logic [4:0]  in_set_day,
  input logic [4:0]  in_set_hour,
  input logic [5:0]  in_set_minute,
  input logic [5:0]  in_set_second,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_is_set,
  input logic [31:0] out_epoch_seconds,
  input logic [11:0] out_cal_year,
  input logic [3:0]  out_cal_month,
  input logic [4:0]  out_cal_day,
  input logic [4:0]  out_cal_hour,
  input logic [5:0]  out_cal_minute,
  input logic [5:0]  out_cal_second
);

  // a held result beat stays valid, with seconds, is_set and year unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_epoch_seconds)
      && $stable(out_is_set) && $stable(out_cal_year))
    else $error("stalled result beat changed");

  // one item at a time: taking a beat closes the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted beat");

  // a new result only comes out of work in progress
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  // unset clock reads back all zeros
  a_unset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_set |-> out_epoch_seconds == 32'd0 && out_cal_year == 12'd0
      && out_cal_month == 4'd0 && out_cal_day == 5'd0 && out_cal_hour == 5'd0
      && out_cal_minute == 6'd0 && out_cal_second == 6'd0)
    else $error("unset result not zero");

  // set clock gives a well-formed calendar time
  a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_set |-> out_cal_month >= 4'd1 && out_cal_month <= 4'd12
      && out_cal_day >= 5'd1 && out_cal_hour < 5'd24 && out_cal_minute < 6'd60
      && out_cal_second < 6'd60 && out_cal_year >= 12'd1970)
    else $error("calendar field out of range");

endmodule

bind calendar_clock_epoch_converter_top cce_checker u_cce_checker (.*);
